/* rtl/jacobi_laplace_stencil_sweep_macros.svh */
`ifndef JACOBI_LAPLACE_STENCIL_SWEEP_MACROS_SVH
`define JACOBI_LAPLACE_STENCIL_SWEEP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define JLS_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("jls assertion failed");

// Next-cycle implication, disabled while dis is high.
`define JLS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("jls assertion failed");

`endif

/* rtl/jls_pkg.sv */
`default_nettype none
package jls_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int VALUE_W_DEF  = 32;
  localparam int ROW_LIMIT    = 1024;
  localparam int ROW_W        = $clog2(ROW_LIMIT);
  localparam int DIM_W        = 11;
  localparam int DIM_MIN      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } jls_qstat_t;

endpackage
`default_nettype wire

/* rtl/jls_front.sv */
`default_nettype none
module jls_front
  import jls_pkg::*;
#(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int COL_W      = $clog2(MAX_COLS),
  localparam int ENTRY_W    = 4 * VALUE_WIDTH + 1 + ROW_W + COL_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [DIM_W-1:0]              cfg_data,
  input  wire logic                          in_push,
  input  wire logic signed [VALUE_WIDTH-1:0] in_cell_value,
  output logic                               in_full,
  input  wire jls_qstat_t                    q_stat,
  output logic                               q_push,
  output logic [ENTRY_W-1:0]                 q_wdata
);

  localparam int CDIM_W   = $clog2(MAX_COLS + 1);
  localparam int CMP_W    = (DIM_W > CDIM_W) ? DIM_W : CDIM_W;
  localparam int COLS_RST = (MAX_COLS < ROW_LIMIT) ? MAX_COLS : ROW_LIMIT;

  logic [DIM_W-1:0]       rows_r;
  logic [CDIM_W-1:0]      cols_r;
  logic [DIM_W-1:0]       rows_clamped;
  logic [CDIM_W-1:0]      cols_clamped;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [DIM_W-1:0]       row_ext;
  logic [CDIM_W-1:0]      col_ext;
  logic                   accept;
  logic                   emit;
  logic                   last;

  logic                   s1_valid_r;
  logic                   s1_emit_r;
  logic                   s1_last_r;
  logic [ROW_W-1:0]       s1_row_r;
  logic [COL_W-1:0]       s1_col_r;
  logic [VALUE_WIDTH-1:0] s1_val_r;
  logic [VALUE_WIDTH-1:0] mid_rd_r;
  logic [VALUE_WIDTH-1:0] up_rd_r;

  logic [VALUE_WIDTH-1:0] win_top_r;
  logic [VALUE_WIDTH-1:0] win_mid_near_r;
  logic [VALUE_WIDTH-1:0] win_mid_far_r;
  logic [VALUE_WIDTH-1:0] left_r;

  logic [VALUE_WIDTH-1:0] middle_mem [MAX_COLS];
  logic [VALUE_WIDTH-1:0] upper_mem  [MAX_COLS];

  always_comb begin
    if (cfg_data < DIM_W'(DIM_MIN)) begin
      rows_clamped = DIM_W'(DIM_MIN);
    end else if (cfg_data > DIM_W'(ROW_LIMIT)) begin
      rows_clamped = DIM_W'(ROW_LIMIT);
    end else begin
      rows_clamped = cfg_data;
    end
    if (CMP_W'(cfg_data) < CMP_W'(DIM_MIN)) begin
      cols_clamped = CDIM_W'(DIM_MIN);
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_COLS)) begin
      cols_clamped = CDIM_W'(MAX_COLS);
    end else begin
      cols_clamped = CDIM_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(ROW_LIMIT);
      cols_r <= CDIM_W'(COLS_RST);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_ROWS: rows_r <= rows_clamped;
        CFG_GRID_COLS: cols_r <= cols_clamped;
      endcase
    end
  end

  assign in_full = (q_stat.count + QCNT_W'(s1_valid_r)) >= QCNT_W'(QUEUE_DEPTH);
  assign accept  = in_push & ~in_full;

  always_comb begin
    row_ext = DIM_W'(row_r);
    col_ext = CDIM_W'(col_r);
    emit = (row_ext >= DIM_W'(2)) && (col_ext >= CDIM_W'(2)) &&
           (row_ext < rows_r) && (col_ext < cols_r);
    last = (row_ext == rows_r - DIM_W'(1)) && (col_ext == cols_r - CDIM_W'(1));
    if (col_ext + CDIM_W'(1) >= cols_r) begin
      col_nxt = '0;
      row_nxt = (row_ext + DIM_W'(1) >= rows_r) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = (row_ext >= rows_r) ? '0 : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_row_r  <= row_r - ROW_W'(1);
      s1_col_r  <= col_r;
      s1_val_r  <= in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd_r          <= middle_mem[col_r];
      middle_mem[col_r] <= in_cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r <= upper_mem[col_r];
    end
    if (s1_valid_r) begin
      upper_mem[s1_col_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_mid_far_r  <= win_mid_near_r;
      win_mid_near_r <= mid_rd_r;
      win_top_r      <= up_rd_r;
      left_r         <= s1_val_r;
    end
  end

  assign q_push  = s1_valid_r & s1_emit_r;
  assign q_wdata = {win_top_r, left_r, win_mid_far_r, mid_rd_r,
                    s1_last_r, s1_row_r, s1_col_r - COL_W'(1)};

endmodule
`default_nettype wire

/* rtl/jls_queue.sv */
`default_nettype none
module jls_queue
  import jls_pkg::*;
#(
  parameter int WIDTH = 4 * VALUE_W_DEF + 1 + ROW_W + $clog2(MAX_COLS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output jls_qstat_t            stat
);

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule
`default_nettype wire

/* rtl/jls_back.sv */
`default_nettype none
module jls_back
  import jls_pkg::*;
#(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int COL_W      = $clog2(MAX_COLS),
  localparam int ENTRY_W    = 4 * VALUE_WIDTH + 1 + ROW_W + COL_W
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [ENTRY_W-1:0]  q_rdata,
  input  wire jls_qstat_t          q_stat,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic signed [VALUE_WIDTH-1:0] out_new_value,
  output logic [ROW_W-1:0]         out_cell_row,
  output logic [COL_W-1:0]         out_cell_col,
  output logic                     out_last_cell
);

  logic signed [VALUE_WIDTH-1:0] op_up, op_down, op_left, op_right;
  logic                          op_last;
  logic [ROW_W-1:0]              op_row;
  logic [COL_W-1:0]              op_col;

  logic                          a_valid_r;
  logic signed [VALUE_WIDTH:0]   sum_ab_r;
  logic signed [VALUE_WIDTH:0]   sum_cd_r;
  logic                          a_last_r;
  logic [ROW_W-1:0]              a_row_r;
  logic [COL_W-1:0]              a_col_r;
  logic signed [VALUE_WIDTH+1:0] sum_all;

  logic                          out_valid_r;
  logic [VALUE_WIDTH-1:0]        out_value_r;
  logic [ROW_W-1:0]              out_row_r;
  logic [COL_W-1:0]              out_col_r;
  logic                          out_last_r;

  logic                          load_a;
  logic                          load_b;

  assign {op_up, op_down, op_left, op_right, op_last, op_row, op_col} = q_rdata;

  assign load_b = a_valid_r & (~out_valid_r | out_pop);
  assign load_a = ~q_stat.empty & (~a_valid_r | load_b);
  assign q_pop  = load_a;

  assign sum_all = {sum_ab_r[VALUE_WIDTH], sum_ab_r} + {sum_cd_r[VALUE_WIDTH], sum_cd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_a) begin
        a_valid_r <= 1'b1;
      end else if (load_b) begin
        a_valid_r <= 1'b0;
      end
      if (load_b) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      sum_ab_r <= {op_up[VALUE_WIDTH-1], op_up} + {op_down[VALUE_WIDTH-1], op_down};
      sum_cd_r <= {op_left[VALUE_WIDTH-1], op_left} + {op_right[VALUE_WIDTH-1], op_right};
      a_last_r <= op_last;
      a_row_r  <= op_row;
      a_col_r  <= op_col;
    end
    if (load_b) begin
      out_value_r <= sum_all[VALUE_WIDTH+1:2];
      out_row_r   <= a_row_r;
      out_col_r   <= a_col_r;
      out_last_r  <= a_last_r;
    end
  end

  assign out_empty     = ~out_valid_r;
  assign out_new_value = out_value_r;
  assign out_cell_row  = out_row_r;
  assign out_cell_col  = out_col_r;
  assign out_last_cell = out_last_r;

endmodule
`default_nettype wire

/* rtl/jacobi_laplace_stencil_sweep.sv */
// A result goes through the front registers, queue, adder stage and output register in turn.
// Throughput: one input per cycle unless in_full, limited by one write port per line store.
// A four-entry queue between the front and the adder lets the output stall without loss.
// Synchronous active-low reset: restores 1024 x min(MAX_COLS, 1024), clears all control state.
// The line stores are not cleared; stale reads only feed cells that are never emitted.
`default_nettype none
module jacobi_laplace_stencil_sweep
  import jls_pkg::*;
#(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int COL_W      = $clog2(MAX_COLS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [DIM_W-1:0]              cfg_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [VALUE_WIDTH-1:0] in_cell_value,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [VALUE_WIDTH-1:0]      out_new_value,
  output logic [ROW_W-1:0]                   out_cell_row,
  output logic [COL_W-1:0]                   out_cell_col,
  output logic                               out_last_cell
);

  localparam int ENTRY_W = 4 * VALUE_WIDTH + 1 + ROW_W + COL_W;

  jls_qstat_t         q_stat;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  assign cfg_ready = 1'b1;

  jls_front #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_cell_value (in_cell_value),
    .in_full       (in_full),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  jls_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  jls_back #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rdata       (q_rdata),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_new_value (out_new_value),
    .out_cell_row  (out_cell_row),
    .out_cell_col  (out_cell_col),
    .out_last_cell (out_last_cell)
  );

endmodule
`default_nettype wire

/* rtl/jls_checker.sv */
`default_nettype none
`include "jacobi_laplace_stencil_sweep_macros.svh"
module jls_checker
  import jls_pkg::*;
#(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int COL_W      = $clog2(MAX_COLS)
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_full,
  input wire logic                   out_empty,
  input wire logic                   out_pop,
  input wire logic [VALUE_WIDTH-1:0] out_new_value,
  input wire logic [ROW_W-1:0]       out_cell_row,
  input wire logic [COL_W-1:0]       out_cell_col,
  input wire logic                   out_last_cell
);

  // A waiting result that is not taken stays unchanged.
  `JLS_ASSERT_NEXT(a_out_hold, clk, !rst_n, !out_empty && !out_pop, !out_empty && $stable(out_new_value) && $stable(out_cell_row) && $stable(out_cell_col) && $stable(out_last_cell))

  // Only interior cells are reported, never row or column zero.
  `JLS_ASSERT_NOW(a_interior, clk, !rst_n, !out_empty, out_cell_row != '0 && out_cell_col != '0)

  // After reset nothing is pending and input is open.
  `JLS_ASSERT_NEXT(a_reset_clear, clk, 1'b0, !rst_n, out_empty && !in_full)

endmodule

bind jacobi_laplace_stencil_sweep jls_checker #(
  .MAX_COLS    (MAX_COLS),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_jls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_new_value (out_new_value),
  .out_cell_row  (out_cell_row),
  .out_cell_col  (out_cell_col),
  .out_last_cell (out_last_cell)
);
`default_nettype wire
